// ===== rtl/core/bba_pkg.sv =====
`default_nettype none
package bba_pkg;

  // Pool geometry.
  localparam int NUM_BLOCKS = 1024;
  localparam int BLK_W      = 10;
  localparam int LINK_W     = 11;
  localparam int NODE_W     = 11;
  localparam int NODES      = 2 * NUM_BLOCKS;
  localparam int LVL_W      = 4;
  localparam int LEVELS     = 11;
  localparam int MIN_ORD    = 5;
  localparam logic [LVL_W-1:0] ORDER_CAP = 4'd10;
  localparam logic [LINK_W-1:0] NO_LINK = 11'd1024;

  // Request kinds.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO      = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_NO_BLOCK  = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_UNL_RD, S_UNL_WR, S_SPLIT_A, S_SPLIT_B,
    S_F_CHECK, S_F_EVAL, S_PUSH_A, S_PUSH_B, S_DONE
  } state_t;

  // Access to the free-bit tree memory.
  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] addr;
    logic              wdata;
  } fb_req_t;

  // Access to one of the link memories.
  typedef struct packed {
    logic              we;
    logic [BLK_W-1:0]  addr;
    logic [LINK_W-1:0] wdata;
  } link_req_t;

  // Rounds a byte count up to a power of two and returns its log2.
  function automatic logic [4:0] ceil_log2(input logic [15:0] x);
    logic [15:0] y;
    logic [4:0]  n;
    y = x - 16'd1;
    n = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (y[i]) n = 5'(i + 1);
    end
    if (x <= 16'd1) n = 5'd0;
    return n;
  endfunction

  // Tree node address of block idx at level lvl.
  function automatic logic [NODE_W-1:0] node_of(input logic [LVL_W-1:0] lvl,
                                                input logic [BLK_W-1:0] idx);
    logic [NODE_W:0] t;
    t = (12'd1 << lvl) + {2'b00, idx} - 12'd1;
    return t[NODE_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bba_ram.sv =====
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Single port, registered read of the old contents.
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/bba_ctrl.sv =====
`default_nettype none
module bba_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [3:0]                 cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       req_type,
  input  wire logic [15:0]                req_size,
  input  wire logic [14:0]                block_offset,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      status,
  output logic [14:0]                     alloc_offset,
  output bba_pkg::fb_req_t                fb_req,
  input  wire logic                       fb_rd,
  output bba_pkg::link_req_t              next_req,
  input  wire logic [bba_pkg::LINK_W-1:0] next_rd,
  output bba_pkg::link_req_t              prev_req,
  input  wire logic [bba_pkg::LINK_W-1:0] prev_rd
);
  import bba_pkg::*;

  state_t state, state_next;

  logic [LVL_W-1:0]  pool_order;
  logic [NODE_W-1:0] clr_cnt;
  logic [LINK_W-1:0] head [0:LEVELS-1];
  logic [LVL_W-1:0]  lvl;
  logic [LVL_W-1:0]  target;
  logic [BLK_W-1:0]  idx;
  logic [BLK_W-1:0]  unl_blk;
  logic              req_type_r;
  logic [15:0]       req_size_r;
  logic [14:0]       block_offset_r;
  logic [1:0]        status_r;
  logic [14:0]       result_r;

  logic              cfg_fire;
  logic [LVL_W-1:0]  cfg_order;
  logic [4:0]        ord;
  logic [4:0]        rel;
  logic              too_big;
  logic [LVL_W-1:0]  tgt;
  logic              found;
  logic [LVL_W-1:0]  found_lv;
  logic [BLK_W-1:0]  found_blk;
  logic [BLK_W-1:0]  fblk;
  logic              off_range;
  logic [LVL_W-1:0]  sh;
  logic [LVL_W-1:0]  nl;
  logic [BLK_W-1:0]  ni;
  logic [BLK_W-1:0]  split_blk;
  logic [BLK_W-1:0]  sb_blk;
  logic [BLK_W-1:0]  push_blk;
  logic [BLK_W-1:0]  bud;
  logic [LINK_W-1:0] cur_head;
  logic              out_load;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign cfg_order = (cfg_data > ORDER_CAP) ? ORDER_CAP : cfg_data;
  assign in_ready  = (state == S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  // Request decode: size class, range checks and the free-list search.
  always_comb begin
    ord       = ceil_log2(req_size_r);
    rel       = (ord > 5'(MIN_ORD)) ? ord - 5'(MIN_ORD) : 5'd0;
    too_big   = rel > {1'b0, pool_order};
    tgt       = pool_order - rel[LVL_W-1:0];
    fblk      = block_offset_r[14:MIN_ORD];
    off_range = (({1'b0, fblk} >> pool_order) != 11'd0);
    found     = 1'b0;
    found_lv  = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if ((LVL_W'(i) <= tgt) && !head[i][BLK_W]) begin
        found    = 1'b1;
        found_lv = LVL_W'(i);
      end
    end
    found_blk = head[found_lv][BLK_W-1:0];
  end

  // Block numbers for splitting, pushing and merging.
  always_comb begin
    sh        = pool_order - lvl;
    nl        = lvl + 4'd1;
    ni        = idx << 1;
    split_blk = (ni + 10'd1) << (pool_order - nl);
    sb_blk    = (idx + 10'd1) << sh;
    push_blk  = idx << sh;
    bud       = idx ^ 10'd1;
    cur_head  = head[lvl];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:   if (clr_cnt == NODE_W'(NODES - 1)) state_next = S_IDLE;
      S_IDLE:    if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (req_type_r == REQ_ALLOC && req_size_r == 16'd0) state_next = S_DONE;
        else if (too_big) state_next = S_DONE;
        else if (req_type_r == REQ_ALLOC) state_next = found ? S_UNL_RD : S_DONE;
        else state_next = off_range ? S_DONE : S_F_CHECK;
      end
      S_UNL_RD:  state_next = S_UNL_WR;
      S_UNL_WR: begin
        if (req_type_r == REQ_FREE) state_next = S_F_CHECK;
        else state_next = (lvl < target) ? S_SPLIT_A : S_DONE;
      end
      S_SPLIT_A: state_next = S_SPLIT_B;
      S_SPLIT_B: state_next = (lvl < target) ? S_SPLIT_A : S_DONE;
      S_F_CHECK: state_next = (lvl == '0) ? S_PUSH_A : S_F_EVAL;
      S_F_EVAL:  state_next = fb_rd ? S_UNL_RD : S_PUSH_A;
      S_PUSH_A:  state_next = S_PUSH_B;
      S_PUSH_B:  state_next = S_DONE;
      S_DONE:    if (out_load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
    if (cfg_fire) state_next = S_CLEAR;
  end

  // Memory accesses for each state.
  always_comb begin
    fb_req   = '0;
    next_req = '0;
    prev_req = '0;
    case (state)
      S_CLEAR: begin
        fb_req = '{we: 1'b1, addr: clr_cnt, wdata: (clr_cnt == '0)};
        if (clr_cnt == '0) begin
          next_req = '{we: 1'b1, addr: '0, wdata: NO_LINK};
          prev_req = '{we: 1'b1, addr: '0, wdata: NO_LINK};
        end
      end
      S_UNL_RD: begin
        next_req.addr = unl_blk;
        prev_req.addr = unl_blk;
      end
      S_UNL_WR: begin
        next_req = '{we: !prev_rd[BLK_W], addr: prev_rd[BLK_W-1:0], wdata: next_rd};
        prev_req = '{we: !next_rd[BLK_W], addr: next_rd[BLK_W-1:0], wdata: prev_rd};
        if (req_type_r == REQ_FREE) fb_req = '{we: 1'b1, addr: node_of(lvl, bud), wdata: 1'b0};
        else fb_req = '{we: 1'b1, addr: node_of(lvl, idx), wdata: 1'b0};
      end
      S_SPLIT_A: begin
        next_req = '{we: 1'b1, addr: split_blk, wdata: head[nl]};
        prev_req = '{we: 1'b1, addr: split_blk, wdata: NO_LINK};
        fb_req   = '{we: 1'b1, addr: node_of(nl, ni + 10'd1), wdata: 1'b1};
      end
      S_SPLIT_B: begin
        prev_req = '{we: !cur_head[BLK_W], addr: cur_head[BLK_W-1:0],
                     wdata: {1'b0, sb_blk}};
        fb_req   = '{we: 1'b1, addr: node_of(lvl, idx), wdata: 1'b0};
      end
      S_F_CHECK: fb_req.addr = node_of(lvl, bud);
      S_PUSH_A: begin
        next_req = '{we: 1'b1, addr: push_blk, wdata: cur_head};
        prev_req = '{we: 1'b1, addr: push_blk, wdata: NO_LINK};
        fb_req   = '{we: 1'b1, addr: node_of(lvl, idx), wdata: 1'b1};
      end
      S_PUSH_B: begin
        prev_req = '{we: !cur_head[BLK_W], addr: cur_head[BLK_W-1:0],
                     wdata: {1'b0, push_blk}};
      end
      default: ;
    endcase
  end

  // Control registers and list heads.
  always_ff @(posedge clk) begin
    if (rst || cfg_fire) begin
      state   <= rst ? S_CLEAR : state_next;
      clr_cnt <= '0;
      for (int i = 0; i < LEVELS; i++) head[i] <= (i == 0) ? '0 : NO_LINK;
      if (rst) begin
        pool_order <= ORDER_CAP;
        out_valid  <= 1'b0;
      end else begin
        pool_order <= cfg_order;
      end
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 11'd1;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_UNL_WR:  if (prev_rd[BLK_W]) head[lvl] <= next_rd;
        S_SPLIT_B: head[lvl] <= {1'b0, sb_blk};
        S_PUSH_B:  head[lvl] <= {1'b0, push_blk};
        default: ;
      endcase
    end
  end

  // Request datapath.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        req_type_r     <= req_type;
        req_size_r     <= req_size;
        block_offset_r <= block_offset;
      end
      S_DECODE: begin
        status_r <= ST_OK;
        result_r <= '0;
        if (req_type_r == REQ_ALLOC && req_size_r == 16'd0) begin
          status_r <= ST_ZERO;
        end else if (too_big) begin
          status_r <= ST_TOO_LARGE;
        end else if (req_type_r == REQ_ALLOC) begin
          if (!found) status_r <= ST_NO_BLOCK;
          lvl      <= found_lv;
          target   <= tgt;
          unl_blk  <= found_blk;
          idx      <= found_blk >> (pool_order - found_lv);
          result_r <= {found_blk, 5'd0};
        end else begin
          if (off_range) status_r <= ST_TOO_LARGE;
          lvl <= tgt;
          idx <= fblk >> rel;
        end
      end
      S_UNL_WR: begin
        if (req_type_r == REQ_FREE) begin
          lvl <= lvl - 4'd1;
          idx <= idx >> 1;
        end
      end
      S_SPLIT_A: begin
        lvl <= nl;
        idx <= ni;
      end
      S_F_EVAL: unl_blk <= bud << sh;
      default: ;
    endcase
    if (out_load) begin
      status       <= status_r;
      alloc_offset <= result_r;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/buddy_block_allocator_top.sv =====
// Binary buddy allocator over a pool of 2^pool_order blocks of 32 bytes.
// Input channel (in_valid/in_ready): req_type 0 allocates req_size bytes,
// req_type 1 frees the block at block_offset of req_size bytes.
// Output channel (out_valid/out_ready): one result per request, status and
// the byte offset of an allocated block (zero on failure and on free).
// Config channel (cfg_valid/cfg_ready): writes pool_order (saturates at 10)
// and reinitializes the pool to one free block.
// Each request is served step by step through the one-port link and
// free-bit memories, which are read and written back once per level. A
// rejected request goes straight to its result without memory steps. One
// request is in work at a time, and the block returns to its idle state
// before it accepts the next.
// After reset and after every config write, the block sweeps the 2048-entry
// free-bit memory and holds in_ready low meanwhile.
// A finished result waits in the output register while out_ready is low;
// the next request is accepted meanwhile and its result waits behind it.
`default_nettype none
module buddy_block_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [15:0] req_size,
  input  wire logic [14:0] block_offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [14:0]      alloc_offset
);
  import bba_pkg::*;

  fb_req_t           fb_req;
  link_req_t         next_req;
  link_req_t         prev_req;
  logic              fb_rd;
  logic [LINK_W-1:0] next_rd;
  logic [LINK_W-1:0] prev_rd;

  // Sequencer with the per-level list heads.
  bba_ctrl u_ctrl (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data,
    .in_valid, .in_ready, .req_type, .req_size, .block_offset,
    .out_valid, .out_ready, .status, .alloc_offset,
    .fb_req, .fb_rd, .next_req, .next_rd, .prev_req, .prev_rd
  );

  // Free flag per tree node.
  bba_ram #(.WIDTH(1), .DEPTH(NODES)) u_fb_ram (
    .clk, .we(fb_req.we), .addr(fb_req.addr), .wdata(fb_req.wdata), .rdata(fb_rd)
  );

  // Forward links of the free lists.
  bba_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BLOCKS)) u_next_ram (
    .clk, .we(next_req.we), .addr(next_req.addr), .wdata(next_req.wdata),
    .rdata(next_rd)
  );

  // Backward links of the free lists.
  bba_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BLOCKS)) u_prev_ram (
    .clk, .we(prev_req.we), .addr(prev_req.addr), .wdata(prev_req.wdata),
    .rdata(prev_rd)
  );

endmodule
`default_nettype wire

// ===== test/buddy_block_allocator_top_tb.sv =====
`default_nettype none
module buddy_block_allocator_top_tb;
  import bba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 60;

  // One request as the sender offers it.
  typedef struct packed {
    logic        kind;
    logic [15:0] size;
    logic [14:0] offs;
  } alloc_req_t;

  // One result as the block returns it.
  typedef struct packed {
    logic [1:0]  st;
    logic [14:0] offs;
  } alloc_rsp_t;

  // A directed row: the request, and a typed-in result where one is known.
  typedef struct packed {
    alloc_req_t req;
    logic       fixed;
    alloc_rsp_t rsp;
  } vector_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        req_type;
  logic [15:0] req_size;
  logic [14:0] block_offset;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [14:0] alloc_offset;

  buddy_block_allocator_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .req_size     (req_size),
    .block_offset (block_offset),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .alloc_offset (alloc_offset)
  );

  // Shadow copy of the pool state.
  int unsigned pool_ord;
  bit          node_free [NODES];
  int unsigned list_head [LEVELS];
  int unsigned next_blk [NUM_BLOCKS];
  int unsigned prev_blk [NUM_BLOCKS];

  alloc_rsp_t  pending_rsp [$];
  alloc_rsp_t  fixed_rsp [$];
  bit          fixed_flag [$];
  int          err_count;
  int          cycle_count;
  bit          hold_out;
  bit          pace_in;
  int unsigned live_offs [$];
  int unsigned live_size [$];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned size_log2(input int unsigned x);
    int unsigned n;
    n = 0;
    if (x <= 1) return 0;
    x = x - 1;
    while (x != 0) begin
      n++;
      x = x >> 1;
    end
    return n;
  endfunction

  function automatic int unsigned node_at(input int unsigned lvl, input int unsigned idx);
    int unsigned n;
    n = (1 << lvl) + idx - 1;
    return (n < NODES) ? n : 0;
  endfunction

  function automatic void shadow_push(input int unsigned lvl, input int unsigned blk);
    int unsigned h;
    h = list_head[lvl];
    if (blk >= NUM_BLOCKS) return;
    next_blk[blk] = h;
    prev_blk[blk] = NUM_BLOCKS;
    if (h < NUM_BLOCKS) prev_blk[h] = blk;
    list_head[lvl] = blk;
  endfunction

  function automatic void list_unlink(input int unsigned lvl, input int unsigned blk);
    int unsigned p;
    int unsigned n;
    if (blk >= NUM_BLOCKS) return;
    p = prev_blk[blk];
    n = next_blk[blk];
    if (p < NUM_BLOCKS) next_blk[p] = n;
    else list_head[lvl] = n;
    if (n < NUM_BLOCKS) prev_blk[n] = p;
  endfunction

  function automatic void pool_clear(input int unsigned ord);
    pool_ord = (ord > 10) ? 10 : ord;
    foreach (node_free[i]) node_free[i] = 1'b0;
    foreach (next_blk[i]) begin
      next_blk[i] = 0;
      prev_blk[i] = 0;
    end
    foreach (list_head[i]) list_head[i] = NUM_BLOCKS;
    shadow_push(0, 0);
    node_free[0] = 1'b1;
  endfunction

  // Computes the result of one request and updates the shadow pool.
  function automatic alloc_rsp_t pool_serve(input alloc_req_t r);
    alloc_rsp_t  res;
    int unsigned rel;
    int unsigned ord;
    int          lv;
    int unsigned lvl;
    int unsigned blk;
    int unsigned idx;
    int unsigned tgt;
    int unsigned bud;
    res = '0;
    ord = size_log2(r.size);
    rel = (ord > MIN_ORD) ? ord - MIN_ORD : 0;
    if (r.kind == REQ_ALLOC && r.size == 0) begin
      res.st = ST_ZERO;
    end else if (rel > pool_ord) begin
      res.st = ST_TOO_LARGE;
    end else if (r.kind == REQ_ALLOC) begin
      tgt = pool_ord - rel;
      lv = int'(tgt);
      while (lv >= 0 && list_head[lv] >= NUM_BLOCKS) lv--;
      if (lv < 0) begin
        res.st = ST_NO_BLOCK;
      end else begin
        lvl = lv;
        blk = list_head[lvl];
        list_unlink(lvl, blk);
        idx = blk >> (pool_ord - lvl);
        node_free[node_at(lvl, idx)] = 1'b0;
        while (lvl < tgt) begin
          lvl++;
          idx = idx << 1;
          shadow_push(lvl, (idx + 1) << (pool_ord - lvl));
          node_free[node_at(lvl, idx + 1)] = 1'b1;
          node_free[node_at(lvl, idx)] = 1'b0;
        end
        res.st = ST_OK;
        res.offs = 15'(blk << MIN_ORD);
      end
    end else begin
      blk = r.offs >> MIN_ORD;
      if (blk >= (1 << pool_ord)) begin
        res.st = ST_TOO_LARGE;
      end else begin
        lvl = pool_ord - rel;
        idx = blk >> (pool_ord - lvl);
        forever begin
          bud = idx ^ 1;
          if (lvl == 0 || !node_free[node_at(lvl, bud)]) begin
            node_free[node_at(lvl, idx)] = 1'b1;
            shadow_push(lvl, idx << (pool_ord - lvl));
            break;
          end
          list_unlink(lvl, bud << (pool_ord - lvl));
          node_free[node_at(lvl, bud)] = 1'b0;
          lvl--;
          idx = idx >> 1;
        end
      end
    end
    return res;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: stalls on its own pattern, or holds off entirely when asked.
  always @(posedge clk) begin
    if (rst || hold_out) out_ready <= 1'b0;
    else if (cycle_count[7:5] == 3'd5) out_ready <= ($urandom_range(0, 3) == 0);
    else if (cycle_count[9:8] == 2'd0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 2) != 0);
  end

  // Result checker.
  always @(posedge clk) begin
    alloc_rsp_t exp_rsp;
    alloc_rsp_t typed;
    bit         has_typed;
    if (!rst && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: result with none expected: status %0d offset %0d",
                 $time, status, alloc_offset);
        err_count++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        typed = fixed_rsp.pop_front();
        has_typed = fixed_flag.pop_front();
        if (has_typed && typed != exp_rsp) begin
          $display("%0t: table row disagrees: table %0d/%0d predicted %0d/%0d", $time,
                   typed.st, typed.offs, exp_rsp.st, exp_rsp.offs);
          err_count++;
        end
        if (status !== exp_rsp.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_rsp.st, status);
          err_count++;
        end
        if (alloc_offset !== exp_rsp.offs) begin
          $display("%0t: alloc_offset expected %0d actual %0d", $time, exp_rsp.offs,
                   alloc_offset);
          err_count++;
        end
      end
    end
  end

  // Offers one request, keeping bursts and gaps, and predicts its result.
  // Valid stays high from one request to the next unless a gap is taken.
  task automatic send_request(input alloc_req_t r, input bit fx, input alloc_rsp_t fr);
    if (pace_in && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r.kind;
    req_size <= r.size;
    block_offset <= r.offs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_rsp.push_back(pool_serve(r));
    fixed_rsp.push_back(fr);
    fixed_flag.push_back(fx);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pool_order(input logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pool_clear(v);
    live_offs.delete();
    live_size.delete();
  endtask

  // Mostly allocates and frees what was allocated, with some noise.
  task automatic random_phase(input int count);
    alloc_req_t r;
    int unsigned k;
    int unsigned top;
    alloc_rsp_t  none;
    none = '0;
    top = (32 << pool_ord) + 8;
    repeat (count) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        r.kind = REQ_ALLOC;
        r.size = (k < 5) ? 16'($urandom()) : 16'($urandom_range(0, top));
        r.offs = 15'($urandom());
      end else if (k < 85 && live_offs.size() != 0) begin
        k = $urandom_range(0, live_offs.size() - 1);
        r.kind = REQ_FREE;
        r.offs = 15'(live_offs[k]);
        r.size = 16'(live_size[k]);
        live_offs.delete(k);
        live_size.delete(k);
      end else begin
        r.kind = REQ_FREE;
        r.size = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, top));
        r.offs = 15'($urandom());
      end
      send_request(r, 1'b0, none);
      if (r.kind == REQ_ALLOC && pending_rsp[$].st == ST_OK) begin
        live_offs.push_back(pending_rsp[$].offs);
        live_size.push_back(r.size);
      end
    end
  endtask

  vector_t vectors [] = '{
    '{'{REQ_ALLOC, 16'd0,     15'd0},     1'b1, '{ST_ZERO, 15'd0}},
    '{'{REQ_ALLOC, 16'd65535, 15'd32767}, 1'b1, '{ST_TOO_LARGE, 15'd0}},
    '{'{REQ_ALLOC, 16'd32769, 15'd0},     1'b1, '{ST_TOO_LARGE, 15'd0}},
    '{'{REQ_FREE,  16'd65535, 15'd0},     1'b1, '{ST_TOO_LARGE, 15'd0}},
    '{'{REQ_ALLOC, 16'd1,     15'd0},     1'b1, '{ST_OK, 15'd0}},
    '{'{REQ_ALLOC, 16'd32,    15'd0},     1'b0, '{ST_OK, 15'd0}},
    '{'{REQ_ALLOC, 16'd33,    15'd0},     1'b0, '{ST_OK, 15'd0}},
    '{'{REQ_ALLOC, 16'd32768, 15'd0},     1'b1, '{ST_NO_BLOCK, 15'd0}},
    '{'{REQ_FREE,  16'd0,     15'd0},     1'b1, '{ST_OK, 15'd0}},
    '{'{REQ_FREE,  16'd32,    15'd63},    1'b1, '{ST_OK, 15'd0}},
    '{'{REQ_FREE,  16'd64,    15'd64},    1'b1, '{ST_OK, 15'd0}},
    '{'{REQ_ALLOC, 16'd32768, 15'd0},     1'b1, '{ST_OK, 15'd0}},
    '{'{REQ_FREE,  16'd32768, 15'd0},     1'b1, '{ST_OK, 15'd0}},
    '{'{REQ_FREE,  16'd32768, 15'd0},     1'b1, '{ST_OK, 15'd0}},
    '{'{REQ_ALLOC, 16'd100,   15'd0},     1'b0, '{ST_OK, 15'd0}},
    '{'{REQ_FREE,  16'd1000,  15'd32767}, 1'b1, '{ST_OK, 15'd0}},
    '{'{REQ_ALLOC, 16'd16384, 15'd0},     1'b0, '{ST_OK, 15'd0}}
  };

  // Stimulus.
  initial begin
    alloc_req_t r;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 4'd0;
    in_valid = 1'b0;
    req_type = REQ_ALLOC;
    req_size = '0;
    block_offset = '0;
    err_count = 0;
    cycle_count = 0;
    hold_out = 1'b0;
    pace_in = 1'b0;
    pool_clear(10);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (vectors[i]) send_request(vectors[i].req, vectors[i].fixed, vectors[i].rsp);
    drain_results();

    // Small pool: an offset beyond it and a size above it are rejected.
    write_pool_order(4'd2);
    r = '{REQ_FREE, 16'd32, 15'd128};
    send_request(r, 1'b1, '{ST_TOO_LARGE, 15'd0});
    r = '{REQ_ALLOC, 16'd256, 15'd0};
    send_request(r, 1'b1, '{ST_TOO_LARGE, 15'd0});
    drain_results();

    // Pool order above the limit saturates.
    write_pool_order(4'd15);
    pace_in = 1'b1;
    random_phase(200);

    // Long hold-off on the receiver while requests keep coming.
    fork
      begin
        hold_out = 1'b1;
        repeat (400) @(posedge clk);
        hold_out = 1'b0;
      end
      random_phase(20);
    join
    drain_results();

    write_pool_order(4'd0);
    random_phase(60);
    drain_results();
    write_pool_order(4'd3);
    random_phase(300);
    drain_results();
    write_pool_order(4'd6);
    random_phase(400);
    drain_results();
    write_pool_order(4'd10);
    random_phase(350);
    drain_results();

    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
